/* hdl/ftrt_pkg.sv */
`default_nettype none
package ftrt_pkg;

  localparam int unsigned KeyW = 291;

  localparam logic [1:0] KindUdp = 2'd1;
  localparam logic [1:0] KindTcp = 2'd2;

  localparam logic [11:0] FlagsSyn    = 12'h002;
  localparam logic [11:0] FlagsSynAck = 12'h012;
  localparam logic [11:0] FlagsFinAck = 12'h011;
  localparam logic [15:0] ShortFrame  = 16'd60;
  localparam logic [31:0] Max32       = 32'hFFFF_FFFF;
  localparam logic [47:0] Max48       = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEQ,
    ST_UPD,
    ST_OUT
  } state_e;

  // flow key: {v6, kind, src_hi, src_lo, dst_hi, dst_lo, sport, dport}
  typedef logic [KeyW-1:0] key_t;

  // the probe as it moves along the cell chain
  typedef struct packed {
    logic        vld;
    logic        hit;
    logic [12:0] idx;
  } probe_t;

endpackage
`default_nettype wire

/* hdl/ftrt_cell.sv */
`default_nettype none
// One slot of the flow table. The probe passes from cell to cell, one hop a
// cycle; the first cell holding the key marks hit.
module ftrt_cell
  import ftrt_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   wr_i,
  input  wire key_t   key_i,
  input  wire logic   used_i,
  input  wire probe_t probe_i,
  output probe_t      probe_o
);

  key_t   key_q;
  probe_t probe_d, probe_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      key_q <= key_i;
    end
  end

  always_comb begin
    probe_d = probe_i;
    if (probe_i.vld && !probe_i.hit && used_i && key_q == key_i) begin
      probe_d.hit = 1'b1;
      probe_d.idx = 13'(Idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule
`default_nettype wire

/* hdl/flow_table_retransmit_tracker_core.sv */
// Channel | Dir | Payload (low bit first)
// s_axis  | in  | tuser: packet_kind, is_ipv6; tdata: src hi/lo, dst hi/lo, ports, seq,
//         |     | offset/flags, header words, frame length
// m_axis  | out | flow_index, table_full, header/payload length, retx, flow and traffic counters
// An item is accepted, then the probe ripples through the cell chain one cell per cycle; ST_SEQ
// then reads the sequence memory (and writes a new flow's entry), ST_UPD writes it for a known
// TCP flow, and ST_OUT presents the result. Other-protocol items go from ST_IDLE to ST_OUT.
// Reset clears counters and the fill count; table contents are not cleared.
// A result is held in the output register until taken; s_axis_tready is low
// while an item is in work or a result waits.
`default_nettype none
module flow_table_retransmit_tracker_core
  import ftrt_pkg::*;
#(
  parameter int unsigned FLOW_ENTRIES = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // packet_kind[1:0], is_ipv6[2]
  input  wire logic [2:0]   s_axis_tuser,
  // source_addr_high[63:0], source_addr_low[127:64], dest_addr_high[191:128],
  // dest_addr_low[255:192], source_port[271:256], dest_port[287:272],
  // sequence_number[319:288], offset_and_flags[335:320], ip_hdr_words[339:336],
  // frame_length[355:340], zero[359:356]
  input  wire logic [359:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // flow_index[7:0], table_full[8], header_length[24:9], payload_length[40:25],
  // retransmitted[41], flows_total[50:42], tcp_flow_count[59:51], packets_total[91:60],
  // tcp_packets[123:92], udp_packets[155:124], tcp_bytes[203:156],
  // udp_bytes[251:204], zero[255:252]
  output logic [255:0]      m_axis_tdata
);

  localparam int unsigned IdxW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(FLOW_ENTRIES + 1);

  state_e state_q, state_d;

  logic [359:0] in_q;
  logic [2:0]   user_q;
  logic [1:0]   kind;
  logic         v6;
  logic [31:0]  seq;
  logic [15:0]  ofl, flen;
  logic [3:0]   ihl;
  key_t         key;

  assign kind = user_q[1:0];
  assign v6   = user_q[2];
  assign seq  = in_q[319:288];
  assign ofl  = in_q[335:320];
  assign ihl  = in_q[339:336];
  assign flen = in_q[355:340];
  assign key  = {v6, kind,
                 v6 ? in_q[63:0] : 64'd0,
                 v6 ? in_q[127:64] : {32'd0, in_q[95:64]},
                 v6 ? in_q[191:128] : 64'd0,
                 v6 ? in_q[255:192] : {32'd0, in_q[223:192]},
                 in_q[271:256], in_q[287:272]};

  logic [CntW-1:0] fill_q;
  logic [CntW-1:0] tcpf_q;
  logic [31:0]     pk_all_q, pk_tcp_q, pk_udp_q;
  logic [47:0]     by_tcp_q, by_udp_q;
  logic [IdxW:0]   cnt_q;

  // cell chain
  probe_t chain [FLOW_ENTRIES+1];
  logic   start;
  logic   ins;
  assign start = (state_q == ST_IDLE) && s_axis_tvalid;

  assign chain[0] = {(state_q == ST_SCAN) && (cnt_q == '0), 1'b0, 13'd0};

  for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
    ftrt_cell #(.Idx(g)) u_cell (
      .clk_i,
      .rst_ni,
      .wr_i    (ins && fill_q[IdxW-1:0] == IdxW'(g)),
      .key_i   (key),
      .used_i  (CntW'(g) < fill_q),
      .probe_i (chain[g]),
      .probe_o (chain[g+1])
    );
  end

  probe_t res_q;
  logic   full_q;
  logic [IdxW-1:0] id_q;
  assign ins = (state_q == ST_SEQ) && !res_q.hit && (fill_q < CntW'(FLOW_ENTRIES));

  // lengths
  logic [7:0]  tp_len0;
  logic [15:0] used, pay0, hlen, plen;
  assign tp_len0 = (kind == KindUdp) ? 8'd8 : {2'b0, ofl[15:12], 2'b0};
  assign used    = 16'd14 + (v6 ? 16'd40 : {10'd0, ihl, 2'b0}) + {8'd0, tp_len0};
  assign pay0    = (flen > used) ? flen - used : 16'd0;
  assign hlen    = (flen == ShortFrame) ? {8'd0, tp_len0} + pay0 : {8'd0, tp_len0};
  assign plen    = (flen == ShortFrame) ? 16'd0 : pay0;

  // sequence memory
  logic [31:0] seq_mem [FLOW_ENTRIES];
  logic [31:0] exp_q;
  logic        retx_q, seq_wr;
  logic [31:0] seq_wd, nx;
  logic [IdxW-1:0] seq_wa;
  logic [11:0] fl;
  assign fl = ofl[11:0];
  assign nx = seq + {16'd0, plen} +
              ((fl == FlagsSyn || fl == FlagsSynAck || fl == FlagsFinAck) ? 32'd1 : 32'd0);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEQ) begin
      exp_q <= seq_mem[res_q.idx[IdxW-1:0]];
    end
    if (seq_wr) begin
      seq_mem[seq_wa] <= seq_wd;
    end
  end

  logic retx_d;
  always_comb begin
    seq_wr = 1'b0;
    seq_wd = nx;
    seq_wa = id_q;
    retx_d = 1'b0;
    if (state_q == ST_SEQ && ins) begin
      seq_wr = 1'b1;
      seq_wa = fill_q[IdxW-1:0];
      seq_wd = (kind == KindTcp) ? nx : 32'd0;
      // new TCP flow: expected starts at nx, the sequence number after this packet
      if (kind == KindTcp) begin
        seq_wd = nx;
      end
    end else if (state_q == ST_UPD && kind == KindTcp && !full_q && res_q.hit) begin
      if ((plen != 16'd0 || ofl[1] || ofl[0]) && seq < exp_q) begin
        retx_d = 1'b1;
      end else begin
        seq_wr = 1'b1;
      end
    end
  end

  // new TCP flow: no retx test is made, since the probe did not hit; write nx

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) begin
        state_d = (s_axis_tuser[1:0] == KindUdp || s_axis_tuser[1:0] == KindTcp) ?
                  ST_SCAN : ST_OUT;
      end
      ST_SCAN: if (cnt_q == (IdxW+1)'(FLOW_ENTRIES)) state_d = ST_SEQ;
      ST_SEQ:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_OUT;
      ST_OUT:  if (m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_OUT);
  end

  logic [31:0] ip1;
  logic [47:0] bsum;
  assign ip1 = 32'd1;

  always_ff @(posedge clk_i) begin
    if (start) in_q <= s_axis_tdata;
    if (start) user_q <= s_axis_tuser;
    if (chain[FLOW_ENTRIES].vld) res_q <= chain[FLOW_ENTRIES];
    if (state_q == ST_SEQ) begin
      full_q <= !res_q.hit && !(fill_q < CntW'(FLOW_ENTRIES));
      id_q   <= res_q.hit ? res_q.idx[IdxW-1:0] : fill_q[IdxW-1:0];
    end
  end

  assign bsum = (kind == KindUdp) ? by_udp_q : by_tcp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      fill_q   <= '0;
      tcpf_q   <= '0;
      pk_all_q <= '0;
      pk_tcp_q <= '0;
      pk_udp_q <= '0;
      by_tcp_q <= '0;
      by_udp_q <= '0;
      retx_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SCAN) cnt_q <= cnt_q + (IdxW+1)'(1);
      else cnt_q <= '0;
      if (start && pk_all_q != Max32) pk_all_q <= pk_all_q + ip1;
      if (ins) begin
        fill_q <= fill_q + CntW'(1);
        if (kind == KindTcp) tcpf_q <= tcpf_q + CntW'(1);
      end
      if (state_q == ST_UPD) begin
        retx_q <= retx_d;
        if (kind == KindUdp) begin
          if (pk_udp_q != Max32) pk_udp_q <= pk_udp_q + ip1;
          by_udp_q <= (bsum > Max48 - {32'd0, flen}) ? Max48 : bsum + {32'd0, flen};
        end else begin
          if (pk_tcp_q != Max32) pk_tcp_q <= pk_tcp_q + ip1;
          by_tcp_q <= (bsum > Max48 - {32'd0, flen}) ? Max48 : bsum + {32'd0, flen};
        end
      end else if (state_q == ST_IDLE) begin
        retx_q <= 1'b0;
      end
    end
  end

  logic        prot;
  logic [8:0]  flows9, tcpf9;
  assign prot   = (kind == KindUdp || kind == KindTcp);
  assign flows9 = (CntW > 9 && fill_q > CntW'(511)) ? 9'd511 : 9'(fill_q);
  assign tcpf9  = (CntW > 9 && tcpf_q > CntW'(511)) ? 9'd511 : 9'(tcpf_q);

  always_comb begin
    m_axis_tdata          = '0;
    m_axis_tdata[7:0]     = (prot && !full_q) ? 8'(id_q) : 8'd0;
    m_axis_tdata[8]       = prot && full_q;
    m_axis_tdata[24:9]    = prot ? hlen : 16'd0;
    m_axis_tdata[40:25]   = prot ? plen : 16'd0;
    m_axis_tdata[41]      = retx_q;
    m_axis_tdata[50:42]   = flows9;
    m_axis_tdata[59:51]   = tcpf9;
    m_axis_tdata[91:60]   = pk_all_q;
    m_axis_tdata[123:92]  = pk_tcp_q;
    m_axis_tdata[155:124] = pk_udp_q;
    m_axis_tdata[203:156] = by_tcp_q;
    m_axis_tdata[251:204] = by_udp_q;
  end

endmodule
`default_nettype wire

/* hdl/ftrt_checker.sv */
`default_nettype none
module ftrt_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [255:0] m_axis_tdata
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

  a_full_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0 && !m_axis_tdata[41])
    else $error("full with index or retx");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a beat");

endmodule

bind flow_table_retransmit_tracker_core ftrt_checker u_ftrt_checker (.*);
`default_nettype wire
